### hw/rtl/detector_hit_finder_charge_decode_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the hit finder with charge decode
// Shared property forms, clocked on the rising edge, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DETECTOR_HIT_FINDER_CHARGE_DECODE_MACROS_SVH
`define DETECTOR_HIT_FINDER_CHARGE_DECODE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent
`define DHFCD_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hit finder assertion failed");

// Consequent checked in the cycle after the antecedent
`define DHFCD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hit finder assertion failed");

`endif

### hw/rtl/dhfcd_pkg.sv
// ----------------------------------------------------------------------------
// dhfcd_pkg
// Widths, limits and charge decode functions for the hit finder.
// ----------------------------------------------------------------------------
package dhfcd_pkg;

  localparam int NUM_CHANNELS_DEF = 64;

  localparam int CHAN_W   = 6;
  localparam int WORD_W   = 14;
  localparam int TIME_W   = 6;
  localparam int CHARGE_W = 8;
  localparam int PED_W    = 8;
  localparam int DEC_W    = 10;  // largest decoded charge is 952
  localparam int SUM_W    = 12;  // largest sum of three is 2520
  localparam int AMP_W    = 13;
  localparam int CNT_W    = 9;   // holds a channel count up to 256

  localparam logic [TIME_W-1:0] TIME_LIMIT = 6'd50;

  // Expand a compressed charge: mantissa shifted by segment plus segment base
  function automatic logic [DEC_W-1:0] decode_lead(input logic [CHARGE_W-1:0] c);
    logic [DEC_W-1:0] base;
    case (c[7:6])
      2'd0:    base = 10'd0;
      2'd1:    base = 10'd16;
      2'd2:    base = 10'd48;
      2'd3:    base = 10'd112;
      default: base = 10'd0;
    endcase
    return (DEC_W'(c[5:0]) << c[7:6]) + base;
  endfunction

  function automatic logic [DEC_W-1:0] decode_tail(input logic [CHARGE_W-1:0] c);
    logic [DEC_W-1:0] base;
    case (c[7:6])
      2'd0:    base = 10'd0;
      2'd1:    base = 10'd64;
      2'd2:    base = 10'd192;
      2'd3:    base = 10'd448;
      default: base = 10'd0;
    endcase
    return (DEC_W'(c[5:0]) << c[7:6]) + base;
  endfunction

endpackage

### hw/rtl/detector_hit_finder_charge_decode.sv
// ----------------------------------------------------------------------------
// detector_hit_finder_charge_decode: per-channel hit finder with charge decode
// Done follows each accepted start beat; one beat accepted every cycle outside reset.
// Three registered stages (select, decode, sum) lie between start and done; busy is high only in rst.
// Synchronous reset clears the stage valid bits and done; outside reset no result is lost or repeated.
// ----------------------------------------------------------------------------
`include "detector_hit_finder_charge_decode_macros.svh"

module detector_hit_finder_charge_decode #(
  parameter int NUM_CHANNELS = dhfcd_pkg::NUM_CHANNELS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [dhfcd_pkg::CHAN_W-1:0]        channel,
  input  logic [dhfcd_pkg::WORD_W-1:0]        word_zero,
  input  logic [dhfcd_pkg::WORD_W-1:0]        word_one,
  input  logic [dhfcd_pkg::WORD_W-1:0]        word_two,
  input  logic [dhfcd_pkg::WORD_W-1:0]        word_three,
  input  logic [dhfcd_pkg::WORD_W-1:0]        word_four,
  input  logic [dhfcd_pkg::PED_W-1:0]         pedestal,
  output logic                                done,
  output logic                                hit_found,
  output logic [dhfcd_pkg::CHAN_W-1:0]        hit_channel,
  output logic [dhfcd_pkg::TIME_W-1:0]        hit_time,
  output logic signed [dhfcd_pkg::AMP_W-1:0]  amplitude
);

  localparam logic [dhfcd_pkg::CNT_W-1:0] NumChan = dhfcd_pkg::CNT_W'(NUM_CHANNELS);

  // Stage 1: select triggering word and its two followers
  logic                             s1_valid;
  logic                             s1_found;
  logic [dhfcd_pkg::CHAN_W-1:0]     s1_channel;
  logic [dhfcd_pkg::TIME_W-1:0]     s1_time;
  logic [dhfcd_pkg::PED_W-1:0]      s1_ped;
  logic [dhfcd_pkg::CHARGE_W-1:0]   s1_lead;
  logic [dhfcd_pkg::CHARGE_W-1:0]   s1_tail_a;
  logic [dhfcd_pkg::CHARGE_W-1:0]   s1_tail_b;

  // Stage 2: decoded charges
  logic                             s2_valid;
  logic                             s2_found;
  logic [dhfcd_pkg::CHAN_W-1:0]     s2_channel;
  logic [dhfcd_pkg::TIME_W-1:0]     s2_time;
  logic [dhfcd_pkg::PED_W-1:0]      s2_ped;
  logic [dhfcd_pkg::DEC_W-1:0]      s2_lead;
  logic [dhfcd_pkg::DEC_W-1:0]      s2_tail_a;
  logic [dhfcd_pkg::DEC_W-1:0]      s2_tail_b;

  logic                             accept;
  logic                             in_range;
  logic [dhfcd_pkg::TIME_W-1:0]     t0, t1, t2;
  logic                             q0, q1, q2;
  logic                             found_next;
  logic [dhfcd_pkg::TIME_W-1:0]     time_next;
  logic [dhfcd_pkg::WORD_W-1:0]     lead_word, tail_a_word, tail_b_word;
  logic [dhfcd_pkg::SUM_W-1:0]      sum;
  logic signed [dhfcd_pkg::AMP_W-1:0] amp_next;

  assign busy   = rst;
  assign accept = start && !busy;

  // Qualify the time of the first three words and check the channel range
  always_comb begin
    t0 = word_zero[dhfcd_pkg::TIME_W-1:0];
    t1 = word_one[dhfcd_pkg::TIME_W-1:0];
    t2 = word_two[dhfcd_pkg::TIME_W-1:0];
    q0 = (t0 != '0) && (t0 < dhfcd_pkg::TIME_LIMIT);
    q1 = (t1 != '0) && (t1 < dhfcd_pkg::TIME_LIMIT);
    q2 = (t2 != '0) && (t2 < dhfcd_pkg::TIME_LIMIT);
    in_range = {{(dhfcd_pkg::CNT_W-dhfcd_pkg::CHAN_W){1'b0}}, channel} < NumChan;
  end

  // Pick the first qualifying position
  always_comb begin
    found_next  = in_range && (q0 || q1 || q2);
    time_next   = '0;
    lead_word   = word_two;
    tail_a_word = word_three;
    tail_b_word = word_four;
    if (q0) begin
      time_next   = t0;
      lead_word   = word_zero;
      tail_a_word = word_one;
      tail_b_word = word_two;
    end else if (q1) begin
      time_next   = t1;
      lead_word   = word_one;
      tail_a_word = word_two;
      tail_b_word = word_three;
    end else if (q2) begin
      time_next   = t2;
    end
    if (!found_next) begin
      time_next = '0;
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      done     <= s2_valid;
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk) begin
    s1_found   <= found_next;
    s1_channel <= found_next ? channel : '0;
    s1_time    <= time_next;
    s1_ped     <= pedestal;
    s1_lead    <= lead_word[dhfcd_pkg::WORD_W-1:dhfcd_pkg::TIME_W];
    s1_tail_a  <= tail_a_word[dhfcd_pkg::WORD_W-1:dhfcd_pkg::TIME_W];
    s1_tail_b  <= tail_b_word[dhfcd_pkg::WORD_W-1:dhfcd_pkg::TIME_W];
  end

  // Stage 2 payload: expand the three charges
  always_ff @(posedge clk) begin
    s2_found   <= s1_found;
    s2_channel <= s1_channel;
    s2_time    <= s1_time;
    s2_ped     <= s1_ped;
    s2_lead    <= dhfcd_pkg::decode_lead(s1_lead);
    s2_tail_a  <= dhfcd_pkg::decode_tail(s1_tail_a);
    s2_tail_b  <= dhfcd_pkg::decode_tail(s1_tail_b);
  end

  // Sum the charges and drop the pedestal
  always_comb begin
    sum = dhfcd_pkg::SUM_W'(s2_lead) + dhfcd_pkg::SUM_W'(s2_tail_a)
        + dhfcd_pkg::SUM_W'(s2_tail_b);
    amp_next = signed'({1'b0, sum})
             - signed'(dhfcd_pkg::AMP_W'(s2_ped));
  end

  // Stage 3: result registers
  always_ff @(posedge clk) begin
    hit_found   <= s2_found;
    hit_channel <= s2_channel;
    hit_time    <= s2_time;
    amplitude   <= s2_found ? amp_next : '0;
  end

  // Checks
  `DHFCD_ASSERT_SAME(a_latency, clk, rst, accept, ##3 done)
  `DHFCD_ASSERT_SAME(a_no_hit_zero, clk, rst, done && !hit_found, (hit_time == '0) && (amplitude == '0) && (hit_channel == '0))
  `DHFCD_ASSERT_SAME(a_hit_time, clk, rst, done && hit_found, (hit_time != '0) && (hit_time < dhfcd_pkg::TIME_LIMIT))
  `DHFCD_ASSERT_SAME(a_amp_range, clk, rst, done && hit_found, (amplitude >= -13'sd255) && (amplitude <= 13'sd2520))
  `DHFCD_ASSERT_NEXT(a_done_source, clk, rst, !s2_valid, !done)

endmodule
